// ===== hdl/nsf_pkg.sv =====
package nsf_pkg;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;

  // result queue depth; one byte pushes at most two results
  localparam int QDEPTH = 4;
  localparam int MAX_PUSH = 2;

  typedef enum logic [2:0] {
    PH_WAIT = 3'd0,
    PH_ADDR = 3'd1,
    PH_DATA = 3'd2,
    PH_HEX1 = 3'd3,
    PH_HEX2 = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    K_START = 2'd0,
    K_ADDR  = 2'd1,
    K_DATA  = 2'd2,
    K_END   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK_CHECKED   = 3'd0,
    ST_OK_UNCHECKED = 3'd1,
    ST_SUM_ERROR    = 3'd2,
    ST_ADDR_OVF     = 3'd3,
    ST_DATA_OVF     = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] char_value;
    logic [6:0] position;
    logic [2:0] status;
    logic [7:0] computed_sum;
    logic [7:0] received_sum;
    logic       last;
  } nsf_result_t;

  localparam nsf_result_t RESULT_ZERO = '0;

  // results produced by one byte
  typedef struct packed {
    logic [1:0]  count;
    nsf_result_t r0;
    nsf_result_t r1;
  } nsf_push_t;

endpackage

// ===== hdl/nsf_parser.sv =====
module nsf_parser #(
  parameter int MAX_ADDR_LEN = 8,
  parameter int MAX_DATA_LEN = 128
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic [7:0]        rx_byte,
  output nsf_pkg::nsf_push_t push
);
  import nsf_pkg::*;

  phase_t     phase, phase_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] got_sum, got_sum_next;
  logic [6:0] char_index, char_index_next;
  logic [7:0] idx_inc;
  logic [7:0] sum_x;
  logic [7:0] got_full;
  nsf_result_t r0, r1;
  logic [1:0] n;

  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [7:0] d;
    if (c <= CH_NINE) d = c - CH_ZERO;
    else d = c - CH_UPPER_A + 8'd10;
    return d[3:0];
  endfunction

  assign idx_inc  = {1'b0, char_index} + 8'd1;
  assign sum_x    = running_sum ^ rx_byte;
  assign got_full = got_sum | {4'd0, hex_nibble(rx_byte)};

  always_comb begin
    phase_next       = phase;
    running_sum_next = running_sum;
    got_sum_next     = got_sum;
    char_index_next  = char_index;
    r0 = RESULT_ZERO;
    r1 = RESULT_ZERO;
    n  = 2'd0;
    unique case (phase)
      PH_WAIT: begin
        if (rx_byte == CH_DOLLAR) begin
          running_sum_next = '0;
          char_index_next  = '0;
          phase_next       = PH_ADDR;
          r0.kind = K_START;
          n = 2'd1;
        end
      end
      PH_ADDR: begin
        if (rx_byte == CH_COMMA) begin
          running_sum_next = sum_x;
          char_index_next  = '0;
          phase_next       = PH_DATA;
        end else if (rx_byte == CH_STAR) begin
          char_index_next = '0;
          phase_next      = PH_HEX1;
        end else begin
          running_sum_next = sum_x;
          char_index_next  = idx_inc[6:0];
          r0.kind       = K_ADDR;
          r0.char_value = rx_byte;
          r0.position   = char_index;
          n = 2'd1;
          if (idx_inc >= 8'(MAX_ADDR_LEN)) begin
            r1.kind         = K_END;
            r1.status       = ST_ADDR_OVF;
            r1.computed_sum = sum_x;
            n = 2'd2;
            phase_next = PH_WAIT;
          end
        end
      end
      PH_DATA: begin
        if (rx_byte == CH_STAR) begin
          phase_next = PH_HEX1;
        end else if (rx_byte == CH_CR) begin
          r0.kind         = K_END;
          r0.status       = ST_OK_UNCHECKED;
          r0.computed_sum = running_sum;
          n = 2'd1;
          phase_next = PH_WAIT;
        end else begin
          running_sum_next = sum_x;
          char_index_next  = idx_inc[6:0];
          r0.kind       = K_DATA;
          r0.char_value = rx_byte;
          r0.position   = char_index;
          n = 2'd1;
          if (idx_inc >= 8'(MAX_DATA_LEN)) begin
            r1.kind         = K_END;
            r1.status       = ST_DATA_OVF;
            r1.computed_sum = sum_x;
            n = 2'd2;
            phase_next = PH_WAIT;
          end
        end
      end
      PH_HEX1: begin
        got_sum_next = {hex_nibble(rx_byte), 4'd0};
        phase_next   = PH_HEX2;
      end
      PH_HEX2: begin
        got_sum_next    = got_full;
        r0.kind         = K_END;
        r0.status       = (got_full == running_sum) ? ST_OK_CHECKED : ST_SUM_ERROR;
        r0.computed_sum = running_sum;
        r0.received_sum = got_full;
        n = 2'd1;
        phase_next = PH_WAIT;
      end
      default: phase_next = PH_WAIT;
    endcase
    if (n == 2'd1) r0.last = 1'b1;
    if (n == 2'd2) r1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_WAIT;
      running_sum <= '0;
      got_sum     <= '0;
      char_index  <= '0;
    end else if (fire) begin
      phase       <= phase_next;
      running_sum <= running_sum_next;
      got_sum     <= got_sum_next;
      char_index  <= char_index_next;
    end
  end

  assign push.count = fire ? n : 2'd0;
  assign push.r0    = r0;
  assign push.r1    = r1;

  // an end result always returns the parser to waiting
  a_end_to_wait: assert property (@(posedge clk) disable iff (rst)
    (fire && n != 2'd0 && ((n == 2'd1 && r0.kind == K_END) || n == 2'd2))
    |=> phase == PH_WAIT)
    else $error("parser not idle after sentence end");

  // two results only on overflow, the second being the end
  a_pair_shape: assert property (@(posedge clk) disable iff (rst)
    (n == 2'd2) |-> (r1.kind == K_END && !r0.last && r1.last &&
                     (r0.kind == K_ADDR || r0.kind == K_DATA)))
    else $error("bad result pair");

  a_wait_start: assert property (@(posedge clk) disable iff (rst)
    (fire && phase == PH_WAIT && rx_byte != CH_DOLLAR) |=> phase == PH_WAIT)
    else $error("left wait without start character");

endmodule

// ===== hdl/nsf_out_queue.sv =====
module nsf_out_queue (
  input  logic               clk,
  input  logic               rst,
  input  nsf_pkg::nsf_push_t push,
  output logic               room,
  output logic               res_valid,
  input  logic               res_ready,
  output nsf_pkg::nsf_result_t head
);
  import nsf_pkg::*;

  localparam int AW = $clog2(QDEPTH);
  localparam int CW = $clog2(QDEPTH + 1);

  nsf_result_t mem [QDEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW-1:0] wp_1;
  logic [CW-1:0] count;
  logic          pop;

  assign wp_1      = wp + 1'b1;
  assign res_valid = (count != '0);
  assign pop       = res_valid && res_ready;
  assign room      = (count <= CW'(QDEPTH - MAX_PUSH));
  assign head      = mem[rp];

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) mem[wp] <= push.r0;
    if (push.count == 2'd2) mem[wp_1] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + AW'(push.count);
      if (pop) rp <= rp + 1'b1;
      count <= count + CW'(push.count) - CW'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0) |-> (count + CW'(push.count) - CW'(pop) <= CW'(QDEPTH)))
    else $error("result queue overflow");

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= CW'(QDEPTH))
    else $error("result queue count out of range");

  a_pop_only: assert property (@(posedge clk) disable iff (rst)
    (pop && push.count == 2'd0) |=> count == $past(count) - 1'b1)
    else $error("queue count did not drop on pop");

endmodule

// ===== hdl/nmea_sentence_framer.sv =====
// channel | signals                       | beat
// rx      | rx_valid rx_ready rx_byte     | one received character
// res     | res_valid res_ready kind char_value position status
//         | computed_sum received_sum last| one framing result
//
// One byte is taken per cycle while rx_ready is high; its results land in a four-entry queue the same edge.
// A byte yields zero, one or two results; the queue drains one result per cycle while res_ready is high.
// rx_ready drops while the queue holds more than two results.
// Synchronous reset empties the queue and returns the parser to waiting for '$'.
module nmea_sentence_framer #(
  parameter int MAX_ADDR_LEN = 8,
  parameter int MAX_DATA_LEN = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_ready,
  input  logic [7:0] rx_byte,
  output logic       res_valid,
  input  logic       res_ready,
  output logic [1:0] kind,
  output logic [7:0] char_value,
  output logic [6:0] position,
  output logic [2:0] status,
  output logic [7:0] computed_sum,
  output logic [7:0] received_sum,
  output logic       last
);
  import nsf_pkg::*;

  nsf_push_t   push;
  nsf_result_t head;
  logic        fire;

  assign fire = rx_valid && rx_ready;

  nsf_parser #(
    .MAX_ADDR_LEN(MAX_ADDR_LEN),
    .MAX_DATA_LEN(MAX_DATA_LEN)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .rx_byte (rx_byte),
    .push    (push)
  );

  nsf_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (rx_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .head      (head)
  );

  assign kind         = head.kind;
  assign char_value   = head.char_value;
  assign position     = head.position;
  assign status       = head.status;
  assign computed_sum = head.computed_sum;
  assign received_sum = head.received_sum;
  assign last         = head.last;

endmodule
